@@ sv/wmf_pkg.sv @@
// wmf_pkg: widths, opcodes, sequencer states and the shared-unit request word
// for the window max-frequency tracker. No dependencies.
package wmf_pkg;

  localparam int VALUE_BITS    = 17;  // index width of the per-value count table
  localparam int COUNT_BITS    = 17;  // width of one count, index width of population
  localparam int IN_VALUE_BITS = 17;  // port width of in_value
  localparam int OUT_BITS      = 17;  // port width of out_max_frequency

  // A population entry can reach 2^VALUE_BITS.
  localparam int POP_BITS = VALUE_BITS + 1;
  localparam int ALU_BITS = (COUNT_BITS > POP_BITS) ? COUNT_BITS : POP_BITS;
  localparam int CLR_BITS = (VALUE_BITS > COUNT_BITS) ? VALUE_BITS : COUNT_BITS;

  localparam int VALUE_DEPTH = 1 << VALUE_BITS;
  localparam int COUNT_DEPTH = 1 << COUNT_BITS;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ZERO = '0;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
  localparam logic [POP_BITS-1:0]   POP_ONE = POP_BITS'(1);
  localparam logic [CLR_BITS-1:0]   CLR_LAST = '1;

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CNT,
    ST_POP_A,
    ST_POP_B
  } state_t;

  // request to the shared +/-1 unit
  typedef struct packed {
    logic [ALU_BITS-1:0] operand;
    logic                dec;
  } alu_req_t;

endpackage

@@ sv/wmf_ram.sv @@
// wmf_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module wmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/wmf_alu.sv @@
// wmf_alu: shared increment/decrement unit used by every item's table updates.
// Depends on wmf_pkg.
module wmf_alu import wmf_pkg::*; (
  input  alu_req_t            req,
  output logic [ALU_BITS-1:0] res
);

  always_comb begin
    if (req.dec) begin
      res = req.operand - ALU_BITS'(1);
    end else begin
      res = req.operand + ALU_BITS'(1);
    end
  end

endmodule

@@ sv/window_max_frequency_tracker_unit.sv @@
// Window max-frequency tracker: one word per accepted start, one result word per item.
// Busy after accept: ST_CNT only if rejected, ST_CNT and ST_POP_B for the first add,
// ST_CNT and ST_POP_A for the last remove of a value, else all three; out_valid
// pulses the cycle after, when start is taken again. The receiver cannot stall:
// out_valid lasts one cycle. Rate is set by the read-modify-write of both tables
// through one +/-1 unit. Sync reset starts a clear pass over both tables, busy high.
module window_max_frequency_tracker_unit import wmf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_opcode,
  input  logic [IN_VALUE_BITS-1:0] in_value,
  output logic                     out_valid,
  output logic [OUT_BITS-1:0]      out_max_frequency,
  output logic                     out_error
);

  // sequencer and item state
  state_t                state_r, state_nxt;
  op_t                   op_r;
  logic [VALUE_BITS-1:0] v_r;
  logic [COUNT_BITS-1:0] c_r, c_nxt;      // count of the value before the item
  logic [COUNT_BITS-1:0] cn_r, cn_nxt;    // count after the item (c +/- 1)
  logic [COUNT_BITS-1:0] cm_r, cm_nxt;    // current maximum frequency
  logic [CLR_BITS-1:0]   clr_r;

  // result word
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_BITS-1:0]   out_max_r, out_max_nxt;
  logic                  out_err_r, out_err_nxt;

  // count table port
  logic                  vc_we;
  logic [VALUE_BITS-1:0] vc_waddr;
  logic [COUNT_BITS-1:0] vc_wdata;
  logic [COUNT_BITS-1:0] vc_rdata;

  // population table port
  logic                  pop_we;
  logic [COUNT_BITS-1:0] pop_waddr;
  logic [POP_BITS-1:0]   pop_wdata;
  logic [COUNT_BITS-1:0] pop_raddr;
  logic [POP_BITS-1:0]   pop_rdata;

  // shared unit
  alu_req_t              alu_req;
  logic [ALU_BITS-1:0]   alu_res;

  logic                  accept;
  logic                  item_err;
  logic                  finish;
  logic                  clr_done;

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign clr_done = (clr_r == CLR_LAST);

  // reject: add at the count limit, or remove of an absent value
  assign item_err = (op_r == OP_ADD) ? (vc_rdata == COUNT_MAX) : (vc_rdata == COUNT_ZERO);

  wmf_ram #(.WIDTH(COUNT_BITS), .DEPTH(VALUE_DEPTH)) u_count_ram (
    .clk   (clk),
    .we    (vc_we),
    .waddr (vc_waddr),
    .wdata (vc_wdata),
    .raddr (VALUE_BITS'(in_value)),
    .rdata (vc_rdata)
  );

  wmf_ram #(.WIDTH(POP_BITS), .DEPTH(COUNT_DEPTH)) u_pop_ram (
    .clk   (clk),
    .we    (pop_we),
    .waddr (pop_waddr),
    .wdata (pop_wdata),
    .raddr (pop_raddr),
    .rdata (pop_rdata)
  );

  wmf_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_CNT;
        end
      end
      ST_CNT: begin
        // first copy of a value has no old population entry to drop
        priority if (item_err) begin
          state_nxt = ST_IDLE;
        end else if (op_r == OP_ADD && vc_rdata == COUNT_ZERO) begin
          state_nxt = ST_POP_B;
        end else begin
          state_nxt = ST_POP_A;
        end
      end
      ST_POP_A: begin
        // last copy removed: nothing to add at count zero
        if (op_r == OP_REMOVE && c_r == COUNT_ONE) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_POP_B;
        end
      end
      ST_POP_B: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath control
  always_comb begin
    vc_we       = 1'b0;
    vc_waddr    = v_r;
    vc_wdata    = COUNT_BITS'(alu_res);
    pop_we      = 1'b0;
    pop_waddr   = c_r;
    pop_wdata   = POP_BITS'(alu_res);
    pop_raddr   = c_r;
    alu_req     = '{operand: ALU_BITS'(pop_rdata), dec: 1'b0};
    c_nxt       = c_r;
    cn_nxt      = cn_r;
    cm_nxt      = cm_r;
    finish      = 1'b0;
    out_err_nxt = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        vc_we     = ((clr_r >> VALUE_BITS) == '0);
        vc_waddr  = clr_r[VALUE_BITS-1:0];
        vc_wdata  = '0;
        pop_we    = ((clr_r >> COUNT_BITS) == '0);
        pop_waddr = clr_r[COUNT_BITS-1:0];
        pop_wdata = '0;
      end
      ST_IDLE: begin
      end
      ST_CNT: begin
        // count word is on the RAM output; step it by one
        alu_req = '{operand: ALU_BITS'(vc_rdata), dec: (op_r == OP_REMOVE)};
        c_nxt   = vc_rdata;
        cn_nxt  = COUNT_BITS'(alu_res);
        if (item_err) begin
          finish      = 1'b1;
          out_err_nxt = 1'b1;
        end else begin
          vc_we = 1'b1;
          if (op_r == OP_ADD && vc_rdata == COUNT_ZERO) begin
            pop_raddr = COUNT_BITS'(alu_res);
          end else begin
            pop_raddr = vc_rdata;
          end
          if (op_r == OP_ADD && vc_rdata == cm_r) begin
            cm_nxt = COUNT_BITS'(alu_res);
          end
        end
      end
      ST_POP_A: begin
        // drop one from population[c], fetch population[c +/- 1]
        alu_req   = '{operand: ALU_BITS'(pop_rdata), dec: 1'b1};
        pop_we    = 1'b1;
        pop_waddr = c_r;
        pop_raddr = cn_r;
        // max falls by one when its last holder leaves
        if (op_r == OP_REMOVE && c_r == cm_r && pop_rdata == POP_ONE) begin
          cm_nxt = cn_r;
        end
        if (op_r == OP_REMOVE && c_r == COUNT_ONE) begin
          finish = 1'b1;
        end
      end
      ST_POP_B: begin
        alu_req   = '{operand: ALU_BITS'(pop_rdata), dec: 1'b0};
        pop_we    = 1'b1;
        pop_waddr = cn_r;
        pop_raddr = cn_r;
        finish    = 1'b1;
      end
      default: begin
      end
    endcase
    out_valid_nxt = finish;
    out_max_nxt   = finish ? OUT_BITS'(cm_nxt) : out_max_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      cm_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cm_r        <= cm_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + CLR_BITS'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= op_t'(in_opcode);
      v_r  <= VALUE_BITS'(in_value);
    end
    c_r       <= c_nxt;
    cn_r      <= cn_nxt;
    out_max_r <= out_max_nxt;
    if (out_valid_nxt) begin
      out_err_r <= out_err_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_max_frequency = out_max_r;
  assign out_error         = out_err_r;

endmodule
